/* rtl/multivariate_polynomial_evaluator_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef MULTIVARIATE_POLYNOMIAL_EVALUATOR_ASSERT_SVH
`define MULTIVARIATE_POLYNOMIAL_EVALUATOR_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define MPE_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define MPE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mpe_pkg.sv */
package mpe_pkg;

  localparam int DEF_MAX_DIM        = 8;
  localparam int DEF_NUM_BINS       = 16;
  localparam int DEF_COEFFS_PER_BIN = 4096;
  localparam int DEF_MAX_ORDER      = 6;

  localparam int TERM_W = 17;
  localparam int SEL_W  = 4;
  localparam int POS_W  = 3;
  localparam int ORD_W  = 3;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  localparam logic [1:0] KIND_COEF   = 2'd0;
  localparam logic [1:0] KIND_CENTER = 2'd1;
  localparam logic [1:0] KIND_ORDER  = 2'd2;
  localparam logic [1:0] KIND_POINT  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         bin;
    logic [11:0]        index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic [3:0]         result_bin;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic              start;
    logic              ofs_en;
    logic [SEL_W-1:0]  ofs_lim;
    logic              pre_en;
    logic [POS_W-1:0]  pre_pos;
    logic [SEL_W-1:0]  pre_sel;
    logic [TERM_W-1:0] rd_t;
    logic              term_en;
    logic              term_one;
    logic              coef_zero;
    logic [POS_W-1:0]  mono_pos;
    logic              acc_en;
    logic              out_load;
    logic              out_err;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             bin_ok;
    logic [ORD_W-1:0] order;
  } dp_stat_t;

endpackage

/* rtl/mpe_dp.sv */
module mpe_dp #(
  parameter int MAX_DIM        = mpe_pkg::DEF_MAX_DIM,
  parameter int NUM_BINS       = mpe_pkg::DEF_NUM_BINS,
  parameter int COEFFS_PER_BIN = mpe_pkg::DEF_COEFFS_PER_BIN,
  parameter int MAX_ORDER      = mpe_pkg::DEF_MAX_ORDER
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mpe_pkg::in_item_t   in_data,
  input  mpe_pkg::ctrl_cmd_t  cmd,
  output mpe_pkg::dp_stat_t   stat,
  output mpe_pkg::out_item_t  out_data
);

  localparam int DEPTH  = NUM_BINS * COEFFS_PER_BIN;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int BIN_IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  logic signed [31:0] coef_mem [DEPTH];
  logic signed [31:0] coef_q_r;
  logic signed [31:0] pb_r [MAX_DIM];
  logic signed [31:0] cp_r [MAX_DIM];
  logic signed [31:0] dp_r [MAX_DIM];
  logic signed [31:0] pre_r [MAX_ORDER];
  logic [2:0]         ord_r [NUM_BINS];
  logic [3:0]         bin_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] sum_r;
  logic               sat_r;
  mpe_pkg::out_item_t out_r;

  logic               bin_in_ok;
  logic               idx_coef_ok;
  logic               idx_dim_ok;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] dp_nxt [MAX_DIM];
  logic               ofs_sat;
  logic signed [32:0] diff;
  logic signed [63:0] qprod;
  logic signed [64:0] qrnd;
  logic signed [48:0] qshift;
  logic signed [31:0] qval;
  logic               qsat;
  logic signed [31:0] mono;
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_val;
  logic               acc_sat;

  assign bin_in_ok   = 32'(in_data.bin) < NUM_BINS;
  assign idx_coef_ok = 32'(in_data.index) < COEFFS_PER_BIN;
  assign idx_dim_ok  = 32'(in_data.index) < MAX_DIM;
  assign wr_addr = AW'(AW'(in_data.bin) * AW'(COEFFS_PER_BIN) + AW'(in_data.index));
  assign rd_addr = AW'(AW'(bin_r) * AW'(COEFFS_PER_BIN) + AW'(cmd.rd_t));

  assign stat.bin_ok = 32'(bin_r) < NUM_BINS;
  assign stat.order  = ord_r[BIN_IW'(bin_r)];

  always_comb begin
    ofs_sat = 1'b0;
    diff    = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      diff = 33'(pb_r[i]) - 33'(cp_r[i]);
      if (diff > 33'sd2147483647) begin
        dp_nxt[i] = 32'sh7fffffff;
        if (SW'(i) <= cmd.ofs_lim[SW-1:0]) ofs_sat = 1'b1;
      end else if (diff < -33'sd2147483648) begin
        dp_nxt[i] = 32'sh80000000;
        if (SW'(i) <= cmd.ofs_lim[SW-1:0]) ofs_sat = 1'b1;
      end else begin
        dp_nxt[i] = diff[31:0];
      end
    end
  end

  always_comb begin
    qprod  = 64'(pre_r[PW'(cmd.pre_pos - 3'd1)]) * 64'(dp_r[cmd.pre_sel[SW-1:0]]);
    qrnd   = 65'(qprod) + 65'sd32768;
    qshift = 49'(qrnd >>> 16);
    qsat   = 1'b0;
    if (qshift > 49'sd2147483647) begin
      qval = 32'sh7fffffff;
      qsat = 1'b1;
    end else if (qshift < -49'sd2147483648) begin
      qval = 32'sh80000000;
      qsat = 1'b1;
    end else begin
      qval = qshift[31:0];
    end
  end

  assign mono = cmd.term_one ? mpe_pkg::ONE_Q16 : pre_r[PW'(cmd.mono_pos)];

  always_comb begin
    acc_sum = 65'(sum_r) + 65'(prod_r);
    acc_sat = acc_sum[64] != acc_sum[63];
    if (acc_sat) begin
      acc_val = acc_sum[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
    end else begin
      acc_val = acc_sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_data.kind == mpe_pkg::KIND_COEF && bin_in_ok && idx_coef_ok) begin
      coef_mem[wr_addr] <= in_data.value;
    end
    coef_q_r <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BINS; i++) ord_r[i] <= '0;
    end else if (cmd.wr_en && in_data.kind == mpe_pkg::KIND_ORDER && bin_in_ok) begin
      ord_r[BIN_IW'(in_data.bin)] <= in_data.value[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && idx_dim_ok) begin
      if (in_data.kind == mpe_pkg::KIND_CENTER) cp_r[SW'(in_data.index)] <= in_data.value;
      if (in_data.kind == mpe_pkg::KIND_POINT) pb_r[SW'(in_data.index)] <= in_data.value;
    end
    if (cmd.start) bin_r <= in_data.bin;
    if (cmd.ofs_en) begin
      for (int i = 0; i < MAX_DIM; i++) dp_r[i] <= dp_nxt[i];
      sum_r <= '0;
      sat_r <= ofs_sat;
    end
    if (cmd.pre_en) begin
      if (cmd.pre_pos == '0) begin
        pre_r[PW'(cmd.pre_pos)] <= dp_r[cmd.pre_sel[SW-1:0]];
      end else begin
        pre_r[PW'(cmd.pre_pos)] <= qval;
        if (qsat) sat_r <= 1'b1;
      end
    end
    if (cmd.term_en) prod_r <= cmd.coef_zero ? 64'sd0 : 64'(coef_q_r) * 64'(mono);
    if (cmd.acc_en) begin
      sum_r <= acc_val;
      if (acc_sat) sat_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_r.result_bin <= bin_r;
      out_r.result     <= cmd.out_err ? 64'sd0 : sum_r;
      out_r.status     <= cmd.out_err ? mpe_pkg::ST_ORDER :
                          (sat_r ? mpe_pkg::ST_SAT : mpe_pkg::ST_OK);
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/mpe_ctrl.sv */
module mpe_ctrl #(
  parameter int MAX_DIM        = mpe_pkg::DEF_MAX_DIM,
  parameter int COEFFS_PER_BIN = mpe_pkg::DEF_COEFFS_PER_BIN,
  parameter int MAX_ORDER      = mpe_pkg::DEF_MAX_ORDER
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  input  mpe_pkg::dp_stat_t  stat,
  output mpe_pkg::ctrl_cmd_t cmd
);

  localparam int SW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OFS  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MONO = 3'd4;
  localparam logic [2:0] S_TERM = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [3:0]                  dim_r;
  logic [SW-1:0]               dimm1_r, dimm1_nxt;
  logic [SW-1:0]               idx_r [MAX_ORDER];
  logic [SW-1:0]               idx_nxt [MAX_ORDER];
  logic [2:0]                  deg_r, deg_nxt;
  logic [2:0]                  p_r, p_nxt;
  logic [2:0]                  order_r, order_nxt;
  logic [mpe_pkg::TERM_W-1:0]  t_r, t_nxt;
  logic                        one_r, one_nxt;
  logic                        err_r, err_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [3:0]                  dim_c;
  logic                        fire;
  logic                        last;
  logic                        j_found;
  logic [2:0]                  j;
  logic                        ord_bad;

  always_comb begin
    if (dim_r == 4'd0) dim_c = 4'd1;
    else if (32'(dim_r) > MAX_DIM) dim_c = 4'(MAX_DIM);
    else dim_c = dim_r;
  end

  assign in_ready = state_r == S_IDLE;
  assign fire     = in_valid && in_ready;
  assign last     = fire && in_data.kind == mpe_pkg::KIND_POINT &&
                    in_data.index == 12'(dim_c - 4'd1);
  assign ord_bad  = stat.order == 3'd0 || 32'(stat.order) > MAX_ORDER;

  always_comb begin
    j_found = 1'b0;
    j       = '0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (3'(i) < deg_r && idx_r[i] != dimm1_r) begin
        j_found = 1'b1;
        j       = 3'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    dimm1_nxt     = dimm1_r;
    deg_nxt       = deg_r;
    p_nxt         = p_r;
    order_nxt     = order_r;
    t_nxt         = t_r;
    one_nxt       = one_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    for (int i = 0; i < MAX_ORDER; i++) idx_nxt[i] = idx_r[i];

    cmd           = '0;
    cmd.wr_en     = fire;
    cmd.start     = last;
    cmd.ofs_lim   = mpe_pkg::SEL_W'(dimm1_r);
    cmd.pre_pos   = p_r;
    cmd.pre_sel   = mpe_pkg::SEL_W'(idx_r[p_r]);
    cmd.rd_t      = t_r;
    cmd.term_one  = one_r;
    cmd.coef_zero = 32'(t_r) >= COEFFS_PER_BIN;
    cmd.mono_pos  = deg_r - 3'd1;
    cmd.out_err   = err_r;

    case (state_r)
      S_IDLE: begin
        if (last) begin
          dimm1_nxt = SW'(dim_c - 4'd1);
          state_nxt = S_OFS;
        end
      end
      S_OFS: begin
        cmd.ofs_en = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        order_nxt = stat.order;
        t_nxt     = '0;
        one_nxt   = 1'b1;
        if (!stat.bin_ok || ord_bad) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          err_nxt   = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_TERM;
      end
      S_MONO: begin
        cmd.pre_en = 1'b1;
        if (p_r == deg_r - 3'd1) state_nxt = S_TERM;
        else p_nxt = p_r + 3'd1;
      end
      S_TERM: begin
        cmd.term_en = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        one_nxt    = 1'b0;
        t_nxt      = t_r + 1'b1;
        p_nxt      = '0;
        state_nxt  = S_MONO;
        if (one_r || !j_found) begin
          if (!one_r && deg_r == order_r) begin
            state_nxt = S_DONE;
          end else begin
            deg_nxt = one_r ? 3'd1 : deg_r + 3'd1;
            for (int i = 0; i < MAX_ORDER; i++) idx_nxt[i] = '0;
          end
        end else begin
          p_nxt = j;
          for (int i = 0; i < MAX_ORDER; i++) begin
            if (3'(i) >= j) idx_nxt[i] = idx_r[j] + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r       <= 4'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) dim_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    dimm1_r <= dimm1_nxt;
    deg_r   <= deg_nxt;
    p_r     <= p_nxt;
    order_r <= order_nxt;
    t_r     <= t_nxt;
    one_r   <= one_nxt;
    err_r   <= err_nxt;
    for (int i = 0; i < MAX_ORDER; i++) idx_r[i] <= idx_nxt[i];
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/multivariate_polynomial_evaluator.sv */
// Evaluates a per-bin multivariate polynomial in Q16.16 at a point whose coordinates arrive
// one per beat; writes of coefficients, centre coordinates and orders, and coordinates that
// are not the last, are taken while the block is idle. An evaluation is started by the
// coordinate with index dimension-1: Q16.16 offsets are formed, bin and order checked and, if
// both are valid, the constant term is accumulated; for every further term each factor of the
// monomial that must be recomputed is computed, then the term is formed and accumulated.
// One shared Q16.16 multiplier step runs per cycle over a stack of prefix products.
// The result then waits in an output register while new write beats are taken.
module multivariate_polynomial_evaluator #(
  parameter int MAX_DIM        = mpe_pkg::DEF_MAX_DIM,
  parameter int NUM_BINS       = mpe_pkg::DEF_NUM_BINS,
  parameter int COEFFS_PER_BIN = mpe_pkg::DEF_COEFFS_PER_BIN,
  parameter int MAX_ORDER      = mpe_pkg::DEF_MAX_ORDER
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mpe_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata
);

  mpe_pkg::ctrl_cmd_t cmd;
  mpe_pkg::dp_stat_t  stat;

  mpe_ctrl #(
    .MAX_DIM        (MAX_DIM),
    .COEFFS_PER_BIN (COEFFS_PER_BIN),
    .MAX_ORDER      (MAX_ORDER)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd)
  );

  mpe_dp #(
    .MAX_DIM        (MAX_DIM),
    .NUM_BINS       (NUM_BINS),
    .COEFFS_PER_BIN (COEFFS_PER_BIN),
    .MAX_ORDER      (MAX_ORDER)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* rtl/mpe_checker.sv */
`include "multivariate_polynomial_evaluator_assert.svh"

module mpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input mpe_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mpe_pkg::out_item_t out_data
);

  `MPE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped")
  `MPE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data), "stalled result changed")
  `MPE_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_data.status == mpe_pkg::ST_ORDER, out_data.result == 64'sd0, "order error with non-zero result")
  `MPE_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, out_data.status == mpe_pkg::ST_OK || out_data.status == mpe_pkg::ST_ORDER || out_data.status == mpe_pkg::ST_SAT, "unknown status code")

endmodule

bind multivariate_polynomial_evaluator mpe_checker u_mpe_checker (.*);

/* tb/mpe_checker.sv */
`timescale 1ns / 100ps

module mpe_scoreboard
  import mpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic [3:0] cfg_wdata,
  output int        fails,
  output int        pending
);

  logic signed [31:0] coef_mem [0:16*4096-1];
  logic [2:0]         bin_ord [0:15];
  logic signed [31:0] centre [0:7];
  logic signed [31:0] coord [0:7];
  logic [3:0]         dim_reg;
  out_item_t          expected_q [$];

  function automatic logic signed [31:0] clip32(input longint x, inout bit sat);
    if (x > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] fix_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 inout bit sat);
    longint p;
    p = longint'(a) * longint'(b);
    p = (p + 64'sd32768) >>> 16;
    return clip32(p, sat);
  endfunction

  function automatic longint add_sat(input longint a, input longint b, inout bit sat);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat = 1'b1;
      s = a[63] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
    end
    return s;
  endfunction

  function automatic longint term_of(input logic [3:0] b, input int t,
                                     input logic signed [31:0] mono);
    if (t >= 4096) return 0;
    return longint'(coef_mem[b*4096+t]) * longint'(mono);
  endfunction

  function automatic out_item_t evaluate_bin(input logic [3:0] b);
    logic signed [31:0] dp [0:7];
    logic signed [31:0] mono;
    int                 idx [0:5];
    int                 dm, ord, t, d, i, j;
    bit                 sat;
    longint             sum;
    out_item_t          r;
    r.result_bin = b;
    r.result = '0;
    r.status = ST_ORDER;
    ord = bin_ord[b];
    if (ord < 1 || ord > 6) return r;
    dm = (dim_reg == 0) ? 1 : (dim_reg > 8) ? 8 : dim_reg;
    sat = 1'b0;
    for (i = 0; i < dm; i++) dp[i] = clip32(longint'(coord[i]) - longint'(centre[i]), sat);
    sum = term_of(b, 0, ONE_Q16);
    t = 1;
    for (d = 1; d <= ord; d++) begin
      for (i = 0; i < d; i++) idx[i] = 0;
      forever begin
        mono = dp[idx[0]];
        for (i = 1; i < d; i++) mono = fix_mul(mono, dp[idx[i]], sat);
        sum = add_sat(sum, term_of(b, t, mono), sat);
        t++;
        j = d - 1;
        while (j >= 0 && idx[j] >= dm - 1) j--;
        if (j < 0) break;
        idx[j]++;
        for (i = j + 1; i < d; i++) idx[i] = idx[j];
      end
    end
    r.result = sum;
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  initial begin
    fails = 0;
    pending = 0;
    dim_reg = 4'd1;
    for (int i = 0; i < 16; i++) bin_ord[i] = '0;
  end

  always @(posedge clk) begin
    int dm;
    out_item_t e;
    if (rst_n) begin
      if (cfg_we) dim_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        dm = (dim_reg == 0) ? 1 : (dim_reg > 8) ? 8 : dim_reg;
        case (in_data.kind)
          KIND_COEF: coef_mem[in_data.bin*4096+in_data.index] = in_data.value;
          KIND_CENTER: if (in_data.index < 8) centre[in_data.index] = in_data.value;
          KIND_ORDER: bin_ord[in_data.bin] = in_data.value[2:0];
          default: begin
            if (in_data.index < 8) begin
              coord[in_data.index] = in_data.value;
              if (in_data.index == dm - 1)
                expected_q = {expected_q, evaluate_bin(in_data.bin)};
            end
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat result %h bin %h status %h", $time,
                   out_data.result, out_data.result_bin, out_data.status);
        end else begin
          e = expected_q.pop_front();
          if (out_data.result !== e.result) begin
            fails++;
            $display("%0t: result expected %h actual %h", $time, e.result, out_data.result);
          end
          if (out_data.result_bin !== e.result_bin) begin
            fails++;
            $display("%0t: result_bin expected %h actual %h", $time, e.result_bin,
                     out_data.result_bin);
          end
          if (out_data.status !== e.status) begin
            fails++;
            $display("%0t: status expected %h actual %h", $time, e.status, out_data.status);
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import mpe_pkg::*;

  localparam int STALL_LIMIT = 60000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [3:0] cfg_wdata;
  int        fails;
  int        pending;

  bit        coef_set [0:15][0:4095];
  logic [2:0] ord_shadow [0:15];
  int        cur_dim;
  int        in_idle_pct;
  bit        quiet;
  int        beats;
  int        stall_cnt;

  multivariate_polynomial_evaluator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mpe_scoreboard u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fails     (fails),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'($urandom_range(0, 262143)) - 32'sd131072;
      5, 6, 7: return $urandom;
      8: return 32'sh7fffffff;
      default: return 32'sh80000000;
    endcase
  endfunction

  function automatic int term_count(input int d, input int o);
    int c;
    c = 1;
    for (int k = 1; k <= o; k++) c = c * (d + k) / k;
    return c;
  endfunction

  task automatic send_beat(input logic [1:0] kind, input logic [3:0] bin,
                           input logic [11:0] index, input logic signed [31:0] value);
    in_item_t it;
    it.kind = kind;
    it.bin = bin;
    it.index = index;
    it.value = value;
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KIND_COEF) coef_set[bin][index] = 1'b1;
    if (kind == KIND_ORDER) ord_shadow[bin] = value[2:0];
    beats++;
  endtask

  task automatic set_dim(input logic [3:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_dim = (v == 0) ? 1 : (v > 8) ? 8 : v;
  endtask

  task automatic evaluate_at(input logic [3:0] bin, input bit extreme);
    int perm [0:7];
    int o, n, k, tmp;
    logic signed [31:0] v;
    o = ord_shadow[bin];
    if (o >= 1 && o <= 6) begin
      n = term_count(cur_dim, o);
      for (int t = 0; t < n; t++)
        if (!coef_set[bin][t]) send_beat(KIND_COEF, bin, 12'(t), rand_q16());
    end
    for (int i = 0; i < 8; i++) perm[i] = i;
    for (int i = cur_dim - 2; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[k];
      perm[k] = tmp;
    end
    for (int i = 0; i < cur_dim; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(KIND_POINT, 4'($urandom), 12'($urandom_range(8, 4095)), $urandom);
      if (extreme) v = perm[i][0] ? 32'sh80000000 : 32'sh7fffffff;
      else v = rand_q16();
      send_beat(KIND_POINT, bin, 12'(perm[i]), v);
    end
  endtask

  task automatic set_order(input logic [3:0] bin, input int o);
    send_beat(KIND_ORDER, bin, 12'($urandom), (32'($urandom) & 32'hffff_fff8) | 32'(o));
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("[multivariate_polynomial_evaluator] ERROR");
      $finish;
    end
  end

  initial begin
    int dims [0:9];
    int o, lim;
    logic [3:0] b;
    dims = '{3, 1, 2, 4, 15, 2, 0, 6, 3, 5};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    stall_cnt = 0;
    quiet = 1'b0;
    in_idle_pct = 25;
    beats = 0;
    cur_dim = 1;
    for (int i = 0; i < 16; i++) ord_shadow[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    evaluate_at(4'd0, 1'b0);
    send_beat(KIND_CENTER, 4'd0, 12'd0, 32'sh80000000);
    for (int i = 1; i < 8; i++) send_beat(KIND_CENTER, 4'($urandom), 12'(i), rand_q16());
    send_beat(KIND_CENTER, 4'd5, 12'hfff, $urandom);
    send_beat(KIND_COEF, 4'd15, 12'hfff, 32'sh7fffffff);
    send_beat(KIND_COEF, 4'd0, 12'd0, 32'sh80000000);
    set_order(4'd1, 7);
    evaluate_at(4'd1, 1'b0);
    set_order(4'd2, 1);
    evaluate_at(4'd2, 1'b1);
    set_dim(4'd2);
    set_order(4'd15, 6);
    evaluate_at(4'd15, 1'b1);
    evaluate_at(4'd15, 1'b0);
    set_order(4'd15, 0);
    evaluate_at(4'd15, 1'b0);

    for (int ph = 0; ph < 10; ph++) begin
      set_dim(4'(dims[ph]));
      in_idle_pct = (ph % 3 == 1) ? 0 : 25;
      if (ph == 9) begin
        quiet = 1'b1;
        in_idle_pct = 0;
      end
      lim = (cur_dim <= 3) ? 6 : (cur_dim <= 5) ? 4 : 3;
      if (dims[ph] == 15) begin
        set_order(4'd7, 4);
        evaluate_at(4'd7, 1'b0);
      end
      while (beats < 120 * (ph + 1) + 30) begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            o = $urandom_range(0, 9) == 0 ? 7 * $urandom_range(0, 1) : $urandom_range(1, lim);
            set_order(4'($urandom), o);
          end
          3, 4: send_beat(KIND_CENTER, 4'($urandom), 12'($urandom_range(0, 15)), rand_q16());
          5: send_beat(KIND_COEF, 4'($urandom), 12'($urandom), rand_q16());
          default: begin
            b = 4'($urandom);
            if (ord_shadow[b] > lim && ord_shadow[b] != 7) set_order(b, $urandom_range(1, lim));
            evaluate_at(b, $urandom_range(0, 15) == 0);
          end
        endcase
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[multivariate_polynomial_evaluator] OK");
    end else begin
      $display("[multivariate_polynomial_evaluator] ERROR");
    end
    $finish;
  end

endmodule
